>>> rtl/multi_domain_event_monitor_macros.svh
`ifndef MULTI_DOMAIN_EVENT_MONITOR_MACROS_SVH
`define MULTI_DOMAIN_EVENT_MONITOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define MDEM_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("mdem assertion failed");

// next-cycle implication, disabled during reset
`define MDEM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("mdem assertion failed");

`endif

>>> rtl/mdem_pkg.sv
`timescale 1ns / 1ps

package mdem_pkg;

   localparam int NUM_DOMAINS_DEF = 9;
   localparam int DOMAIN_W        = 4;

   localparam logic [2:0] OP_BEGIN    = 3'd0;
   localparam logic [2:0] OP_NOTIFY   = 3'd1;
   localparam logic [2:0] OP_COMPLETE = 3'd2;
   localparam logic [2:0] OP_TIMEOUT  = 3'd3;
   localparam logic [2:0] OP_FINALIZE = 3'd4;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_PASS = 2'd2;
   localparam logic [1:0] ST_FAIL = 2'd3;

   localparam logic [2:0] RS_NONE    = 3'd0;
   localparam logic [2:0] RS_DUP     = 3'd1;
   localparam logic [2:0] RS_TIMEOUT = 3'd2;
   localparam logic [2:0] RS_BAD     = 3'd3;
   localparam logic [2:0] RS_MISSING = 3'd4;

   typedef struct packed {
      logic [2:0]          opcode;
      logic [DOMAIN_W-1:0] domain_id;
      logic [31:0]         event_goal;
      logic [63:0]         limit_tick;
      logic [63:0]         tick;
      logic [63:0]         wall_time_us;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [1:0]  domain_status;
      logic [2:0]  domain_reason;
      logic [63:0] start_stamp;
      logic [63:0] end_stamp;
      logic [63:0] start_wall;
      logic [63:0] end_wall;
      logic [31:0] seen_events;
      logic        is_final;
      logic        all_passed;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  reason;
      logic [63:0] first_tick;
      logic [63:0] start_wall;
      logic [63:0] last_tick;
      logic [63:0] end_wall;
      logic [31:0] expected;
      logic [31:0] observed;
   } rec_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic sweep_start;
      logic sweep_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic fin_new;
      logic sweep_last;
   } ctl_sts_type;

endpackage

>>> rtl/mdem_datapath.sv
`timescale 1ns / 1ps

module mdem_datapath #(
   parameter int NUM_DOMAINS = mdem_pkg::NUM_DOMAINS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mdem_pkg::req_type     req_data,
   input  mdem_pkg::ctl_cmd_type cmd,
   output mdem_pkg::ctl_sts_type sts,
   output mdem_pkg::rsp_type     rsp_data
);
   import mdem_pkg::*;

   localparam int IDX_W = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;

   req_type          item_ff;
   rec_type          rec_ff [NUM_DOMAINS];
   rec_type          rec_in [NUM_DOMAINS];
   logic             final_ff;
   logic             final_in;
   logic             pass_ff;
   logic             pass_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             dom_ok;
   logic             open;
   logic [IDX_W-1:0] dom_idx;
   rec_type          cur;
   rec_type          upd;
   rec_type          sw;
   logic             ok;
   logic [31:0]      obs_inc;

   assign dom_ok  = {1'b0, item_ff.domain_id} < (DOMAIN_W + 1)'(NUM_DOMAINS);
   assign open    = dom_ok && !final_ff;
   assign dom_idx = item_ff.domain_id[IDX_W-1:0];
   assign cur     = dom_ok ? rec_ff[dom_idx] : '0;
   assign obs_inc = cur.observed + 32'd1;

   // apply one operation to the addressed record
   always_comb begin
      upd = cur;
      ok  = 1'b0;
      case (item_ff.opcode)
         OP_BEGIN: begin
            if (open) begin
               if (cur.status != ST_IDLE) begin
                  upd.status    = ST_FAIL;
                  upd.reason    = RS_DUP;
                  upd.last_tick = item_ff.tick;
                  upd.end_wall  = item_ff.wall_time_us;
               end else begin
                  upd.status     = ST_RUN;
                  upd.first_tick = item_ff.tick;
                  upd.start_wall = item_ff.wall_time_us;
                  upd.expected   = item_ff.event_goal;
                  ok             = 1'b1;
               end
            end
         end
         OP_NOTIFY: begin
            if (open) begin
               if (cur.status != ST_RUN) begin
                  upd.status    = ST_FAIL;
                  upd.reason    = RS_BAD;
                  upd.last_tick = item_ff.tick;
                  upd.end_wall  = item_ff.wall_time_us;
               end else begin
                  upd.observed = obs_inc;
                  if (obs_inc > cur.expected) begin
                     upd.status    = ST_FAIL;
                     upd.reason    = RS_DUP;
                     upd.last_tick = item_ff.tick;
                     upd.end_wall  = item_ff.wall_time_us;
                  end else begin
                     ok = 1'b1;
                  end
               end
            end
         end
         OP_COMPLETE: begin
            if (open) begin
               if (cur.status != ST_RUN || cur.observed != cur.expected) begin
                  upd.status    = ST_FAIL;
                  upd.reason    = RS_BAD;
                  upd.last_tick = item_ff.tick;
                  upd.end_wall  = item_ff.wall_time_us;
               end else begin
                  upd.status    = ST_PASS;
                  upd.last_tick = item_ff.tick;
                  upd.end_wall  = item_ff.wall_time_us;
                  ok            = 1'b1;
               end
            end
         end
         OP_TIMEOUT: begin
            if (open) begin
               if (cur.status == ST_RUN && item_ff.tick > item_ff.limit_tick) begin
                  upd.status    = ST_FAIL;
                  upd.reason    = RS_TIMEOUT;
                  upd.last_tick = item_ff.tick;
                  upd.end_wall  = item_ff.wall_time_us;
               end else begin
                  ok = 1'b1;
               end
            end
         end
         OP_FINALIZE: begin
            ok = pass_ff;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // sweep one record per cycle during finalize
   always_comb begin
      sw = rec_ff[idx_ff];
      if (sw.status != ST_PASS && sw.status != ST_FAIL) begin
         sw.status = ST_FAIL;
         sw.reason = RS_MISSING;
      end
   end

   always_comb begin
      rec_in = rec_ff;
      if (cmd.exec && open) begin
         rec_in[dom_idx] = upd;
      end
      if (cmd.sweep_step) begin
         rec_in[idx_ff] = sw;
      end
   end

   always_comb begin
      pass_in  = pass_ff;
      final_in = final_ff;
      idx_in   = idx_ff;
      if (cmd.sweep_start) begin
         pass_in = 1'b1;
         idx_in  = '0;
      end
      if (cmd.sweep_step) begin
         if (rec_ff[idx_ff].status != ST_PASS) begin
            pass_in = 1'b0;
         end
         if (sts.sweep_last) begin
            final_in = 1'b1;
         end
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in               = rsp_ff;
      if (cmd.exec) begin
         rsp_in.ok            = ok;
         rsp_in.domain_status = upd.status;
         rsp_in.domain_reason = upd.reason;
         rsp_in.start_stamp   = upd.first_tick;
         rsp_in.end_stamp     = upd.last_tick;
         rsp_in.start_wall    = upd.start_wall;
         rsp_in.end_wall      = upd.end_wall;
         rsp_in.seen_events   = upd.observed;
         rsp_in.is_final      = final_ff;
         rsp_in.all_passed    = pass_ff;
      end
   end

   assign sts.fin_new    = (item_ff.opcode == OP_FINALIZE) && !final_ff;
   assign sts.sweep_last = idx_ff == IDX_W'(NUM_DOMAINS - 1);
   assign rsp_data       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DOMAINS; i++) begin
            rec_ff[i] <= '0;
         end
         final_ff <= 1'b0;
         pass_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         rec_ff   <= rec_in;
         final_ff <= final_in;
         pass_ff  <= pass_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

endmodule

>>> rtl/mdem_ctrl.sv
`timescale 1ns / 1ps

module mdem_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mdem_pkg::ctl_cmd_type cmd,
   input  mdem_pkg::ctl_sts_type sts
);
   import mdem_pkg::*;

   `include "multi_domain_event_monitor_macros.svh"

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_SWEEP  = 2'd2;
   localparam logic [1:0] S_REPORT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.fin_new) begin
               cmd.sweep_start = 1'b1;
               state_in        = S_SWEEP;
            end else if (out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_REPORT;
            end
         end
         S_REPORT: begin
            if (out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MDEM_ASSERT_NOW(a_load_free, clock, reset, cmd.exec, !rsp_valid_ff || rsp_ready)
   `MDEM_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == S_EXEC)
   `MDEM_ASSERT_NEXT(a_sweep_end, clock, reset, cmd.sweep_step && sts.sweep_last, state_ff == S_REPORT)

endmodule

>>> rtl/multi_domain_event_monitor.sv
`timescale 1ns / 1ps

// channel   dir   handshake              payload
// req_      in    req_valid / req_ready  req_data  (mdem_pkg::req_type)
// rsp_      out   rsp_valid / rsp_ready  rsp_data  (mdem_pkg::rsp_type)
//
// Per-domain operations capture the beat, then execute and load the response
// register. The first finalize starts the sweep, sweeps each record and then
// reports; the sweep visits one record per cycle. A new beat is taken while the
// previous response waits; execution stalls only while the response register
// is full and not drained. Synchronous reset clears all records and flags.

module multi_domain_event_monitor #(
   parameter int NUM_DOMAINS = mdem_pkg::NUM_DOMAINS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mdem_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mdem_pkg::rsp_type rsp_data
);
   import mdem_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   mdem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mdem_datapath #(
      .NUM_DOMAINS (NUM_DOMAINS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
